[rtl/lc3ie_pkg.sv]
// Shared types, codes and constants of the LC-3 execute unit.
`timescale 1ns / 1ps
package lc3ie_pkg;

  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_SETPC = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_JMP  = 4'd12,
    OP_RET7 = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } state_e;

  localparam logic [2:0] FLAG_P = 3'b001;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_N = 3'b100;

  localparam logic [1:0] COND_POS  = 2'd0;
  localparam logic [1:0] COND_ZERO = 2'd1;
  localparam logic [1:0] COND_NEG  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] instruction;
    logic [15:0] address;
    logic [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [1:0]  cond;
    logic        dest_written;
    logic [2:0]  dest_index;
    logic [15:0] dest_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic        trap_request;
    logic [7:0]  trap_number;
    logic        unimplemented;
  } out_item_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'h0000) f = FLAG_Z;
    else if (v[15]) f = FLAG_N;
    else f = FLAG_P;
    return f;
  endfunction

  function automatic logic [1:0] cond_of(input logic [2:0] f);
    logic [1:0] c;
    if (f[2]) c = COND_NEG;
    else if (f[1]) c = COND_ZERO;
    else c = COND_POS;
    return c;
  endfunction

endpackage

[rtl/lc3ie_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lc3ie_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/lc3_instruction_execute_core.sv]
// Top level of the LC-3 execute unit: sequencer, register file, PC, flags.
//  channel | dir | signals                        | payload
//  in      | in  | in_valid_i / in_ready_o        | lc3ie_pkg::in_item_t
//  out     | out | out_valid_o / out_ready_i      | lc3ie_pkg::out_item_t
// Other items finish in ST_IDLE; LD, LDR, STI also pass ST_RD1, LDI ST_RD1 and ST_RD2,
// set by the single port of the word memory (one access per cycle, registered read).
// The result sits in an output register; a new item is taken while it drains.
// Reset clears registers, PC and holds Z; word memory is not cleared.
// A stalled output holds the sequencer at its current step, but LDI leaves ST_RD1 for ST_RD2 without waiting.
`timescale 1ns / 1ps
module lc3_instruction_execute_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lc3ie_pkg::in_item_t   in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lc3ie_pkg::out_item_t  out_o
);
  import lc3ie_pkg::*;

  state_e    state_q, state_d;
  logic [15:0] regs_q [8];
  logic [15:0] pc_q, pc_d;
  logic [2:0]  flags_q, flags_d;
  logic [15:0] ins_q, ins_d;
  logic        out_valid_q;
  out_item_t   out_q, res;
  logic        res_load;
  logic        reg_we;
  logic [2:0]  reg_idx;
  logic [15:0] reg_val;

  logic                 ram_we, ram_re;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [15:0]          ram_wdata, ram_rdata;

  logic        slot_free, fire;
  logic [15:0] ins, pc1, off9, off6, off11, opb, sum9, sum6;
  opcode_e     op, op_q;
  logic [2:0]  r9, r6;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign fire = in_valid_i && in_ready_o;

  assign ins   = in_i.instruction;
  assign op    = opcode_e'(ins[15:12]);
  assign op_q  = opcode_e'(ins_q[15:12]);
  assign r9    = ins[11:9];
  assign r6    = ins[8:6];
  assign pc1   = pc_q + 16'd1;
  assign off9  = {{7{ins[8]}}, ins[8:0]};
  assign off6  = {{10{ins[5]}}, ins[5:0]};
  assign off11 = {{5{ins[10]}}, ins[10:0]};
  assign opb   = ins[5] ? {{11{ins[4]}}, ins[4:0]} : regs_q[ins[2:0]];
  assign sum9  = pc1 + off9;
  assign sum6  = regs_q[r6] + off6;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire && mode_e'(in_i.mode) == MODE_EXEC &&
            (op == OP_LD || op == OP_LDI || op == OP_LDR || op == OP_STI)) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        if (op_q == OP_LDI) state_d = ST_RD2;
        else if (slot_free) state_d = ST_IDLE;
      end
      ST_RD2: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pc_d      = pc_q;
    flags_d   = flags_q;
    ins_d     = ins_q;
    reg_we    = 1'b0;
    reg_idx   = 3'd0;
    reg_val   = 16'd0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = in_i.address[ADDR_BITS-1:0];
    ram_wdata = in_i.data;
    res       = '0;
    res_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          ins_d = ins;
          case (mode_e'(in_i.mode))
            MODE_WRITE: begin
              ram_we   = 1'b1;
              res_load = 1'b1;
            end
            MODE_SETPC: begin
              pc_d     = in_i.address;
              res_load = 1'b1;
            end
            MODE_EXEC: begin
              pc_d     = pc1;
              res_load = 1'b1;
              case (op)
                OP_BR: begin
                  if (r9 == 3'd0 || (r9 & flags_q) != 3'd0) pc_d = sum9;
                end
                OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
                  reg_we  = 1'b1;
                  reg_idx = r9;
                  if (op == OP_ADD) reg_val = regs_q[r6] + opb;
                  else if (op == OP_AND) reg_val = regs_q[r6] & opb;
                  else if (op == OP_NOT) reg_val = ~regs_q[r6];
                  else reg_val = sum9;
                  flags_d = flags_of(reg_val);
                end
                OP_LD, OP_LDI, OP_STI: begin
                  ram_re   = 1'b1;
                  ram_addr = sum9[ADDR_BITS-1:0];
                  res_load = 1'b0;
                end
                OP_LDR: begin
                  ram_re   = 1'b1;
                  ram_addr = sum6[ADDR_BITS-1:0];
                  res_load = 1'b0;
                end
                OP_ST, OP_STR: begin
                  ram_we    = 1'b1;
                  ram_addr  = (op == OP_ST) ? sum9[ADDR_BITS-1:0] : sum6[ADDR_BITS-1:0];
                  ram_wdata = regs_q[r9];
                  res.mem_written = 1'b1;
                  res.mem_address = 16'(ram_addr);
                end
                OP_JMP:  pc_d = regs_q[r6];
                OP_RET7: pc_d = regs_q[7];
                OP_JSR: begin
                  pc_d    = ins[11] ? pc1 + off11 : regs_q[r6];
                  reg_we  = 1'b1;
                  reg_idx = 3'd7;
                  reg_val = pc1;
                end
                OP_TRAP: begin
                  res.trap_request = 1'b1;
                  res.trap_number  = ins[7:0];
                end
                default: res.unimplemented = 1'b1;
              endcase
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_RD1: begin
        if (op_q == OP_LDI) begin
          ram_re   = 1'b1;
          ram_addr = ram_rdata[ADDR_BITS-1:0];
        end else if (slot_free) begin
          res_load = 1'b1;
          if (op_q == OP_STI) begin
            ram_we    = 1'b1;
            ram_addr  = ram_rdata[ADDR_BITS-1:0];
            ram_wdata = regs_q[ins_q[11:9]];
            res.mem_written = 1'b1;
            res.mem_address = 16'(ram_addr);
          end else begin
            reg_we  = 1'b1;
            reg_idx = ins_q[11:9];
            reg_val = ram_rdata;
            flags_d = flags_of(ram_rdata);
          end
        end
      end
      ST_RD2: begin
        if (slot_free) begin
          res_load = 1'b1;
          reg_we   = 1'b1;
          reg_idx  = ins_q[11:9];
          reg_val  = ram_rdata;
          flags_d  = flags_of(ram_rdata);
        end
      end
      default: ;
    endcase
    res.dest_written = reg_we;
    res.dest_index   = reg_idx;
    res.dest_value   = reg_val;
    res.pc           = pc_d;
    res.cond         = cond_of(flags_d);
  end

  lc3ie_ram #(
    .WIDTH(16),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= 16'd0;
      flags_q     <= FLAG_Z;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) regs_q[i] <= 16'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      flags_q <= flags_d;
      if (reg_we) regs_q[reg_idx] <= reg_val;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    if (res_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
endmodule

[rtl/lc3ie_checker.sv]
// Port-level checker for the LC-3 execute unit, bound to the top level.
`timescale 1ns / 1ps
module lc3ie_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input lc3ie_pkg::out_item_t out_o
);
  import lc3ie_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output item dropped or changed while stalled");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken with no room for its result");

  a_cond_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.cond != 2'd3)
    else $error("bad condition code");

  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.dest_written && out_o.mem_written) &&
                    !(out_o.trap_request && out_o.dest_written))
    else $error("result reports conflicting effects");
endmodule

bind lc3_instruction_execute_core lc3ie_checker u_lc3ie_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_o      (out_o)
);
